// ===== sv/rrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the rounded rectangle path generator.
// No dependencies.
package rrp_pkg;

    localparam int COORD_W     = 16;
    localparam int PT_W        = 26;
    localparam int HALF_W      = 20;
    localparam int EXT_W       = 17;
    localparam int STEP_W      = 4;
    localparam int CMD_W       = 3;
    localparam int KAPPA_NUM   = 36195;
    localparam int KAPPA_SHIFT = 16;
    localparam int FRAC_SHIFT  = 7;
    localparam int PROD_W      = COORD_W + KAPPA_SHIFT;

    typedef logic signed [HALF_W-1:0] half_t;
    typedef logic signed [PT_W-1:0]   pt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_MOVE  = 3'd0,
        CMD_LINE  = 3'd1,
        CMD_CUBIC = 3'd2,
        CMD_CLOSE = 3'd3,
        CMD_END   = 3'd4
    } cmd_t;

    function automatic pt_t fix_pt(input half_t c);
        return {c[PT_W-FRAC_SHIFT-1:0], {FRAC_SHIFT{1'b0}}};
    endfunction

endpackage

// ===== sv/rrp_rect_if.sv =====
`timescale 1ns / 1ps
// Rectangle request channel: valid/ready handshake plus rectangle fields.
// Depends on rrp_pkg.
interface rrp_rect_if;
    logic                              valid;
    logic                              ready;
    logic signed [rrp_pkg::COORD_W-1:0] rect_x;
    logic signed [rrp_pkg::COORD_W-1:0] rect_y;
    logic        [rrp_pkg::COORD_W-1:0] rect_width;
    logic        [rrp_pkg::COORD_W-1:0] rect_height;
    logic        [rrp_pkg::COORD_W-1:0] corner_radius;
    logic                              pixel_adjust;

    modport source (
        output valid, rect_x, rect_y, rect_width, rect_height, corner_radius, pixel_adjust,
        input  ready
    );
    modport sink (
        input  valid, rect_x, rect_y, rect_width, rect_height, corner_radius, pixel_adjust,
        output ready
    );
endinterface

// ===== sv/rrp_path_if.sv =====
`timescale 1ns / 1ps
// Path command channel: valid/ready handshake plus one command and its points.
// Depends on rrp_pkg.
interface rrp_path_if;
    logic                            valid;
    logic                            ready;
    logic [rrp_pkg::CMD_W-1:0]       cmd_code;
    logic signed [rrp_pkg::PT_W-1:0] pt1_x;
    logic signed [rrp_pkg::PT_W-1:0] pt1_y;
    logic signed [rrp_pkg::PT_W-1:0] pt2_x;
    logic signed [rrp_pkg::PT_W-1:0] pt2_y;
    logic signed [rrp_pkg::PT_W-1:0] pt3_x;
    logic signed [rrp_pkg::PT_W-1:0] pt3_y;
    logic                            is_last;

    modport source (
        output valid, cmd_code, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, is_last,
        input  ready
    );
    modport sink (
        input  valid, cmd_code, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, is_last,
        output ready
    );
endinterface

// ===== sv/rounded_rect_path_gen.sv =====
`timescale 1ns / 1ps
// Rounded rectangle path generator: rectangle in, path commands out.
// Depends on rrp_pkg, rrp_rect_if, rrp_path_if.
// A rectangle reaches the path channel through the input, geometry and result registers.
// Throughput: one command per cycle while the path channel is ready; a rectangle
// yields 1, 6 or 10 commands, and the command sequencer sets the sustained rate.
// Reset: all valid flags clear; no rectangle or command is in flight.
module rounded_rect_path_gen
(
    input  logic       clk,
    input  logic       rst_n,
    rrp_rect_if.sink   rect,
    rrp_path_if.source path
);

    typedef enum logic [1:0] {
        KIND_EMPTY,
        KIND_PLAIN,
        KIND_ROUND
    } kind_t;

    localparam logic [rrp_pkg::STEP_W-1:0] LAST_PLAIN = rrp_pkg::STEP_W'(5);

    // input register
    logic                               raw_valid_reg;
    logic signed [rrp_pkg::COORD_W-1:0] raw_x_reg;
    logic signed [rrp_pkg::COORD_W-1:0] raw_y_reg;
    logic        [rrp_pkg::COORD_W-1:0] raw_w_reg;
    logic        [rrp_pkg::COORD_W-1:0] raw_h_reg;
    logic        [rrp_pkg::COORD_W-1:0] raw_rad_reg;
    logic                               raw_adj_reg;

    // geometry register
    logic                              geom_valid_reg;
    kind_t                             kind_reg, kind_next;
    rrp_pkg::half_t                    x0_reg, x0_next, y0_reg, y0_next;
    rrp_pkg::half_t                    x1_reg, x1_next, y1_reg, y1_next;
    rrp_pkg::half_t                    l_reg, l_next, r_reg, r_next;
    rrp_pkg::half_t                    t_reg, t_next, b_reg, b_next;
    logic [rrp_pkg::COORD_W-1:0]       hk_reg, hk_next, vk_reg, vk_next;
    logic [rrp_pkg::STEP_W-1:0]        step_reg;

    // result register
    logic                              out_valid_reg;
    rrp_pkg::cmd_t                     cmd_reg, cmd_next;
    rrp_pkg::pt_t                      p1x_reg, p1y_reg, p2x_reg, p2y_reg, p3x_reg, p3y_reg;
    rrp_pkg::half_t                    p1x_next, p1y_next, p2x_next, p2y_next;
    rrp_pkg::half_t                    p3x_next, p3y_next;

    logic [rrp_pkg::EXT_W-1:0]         aw, ah, rad2;
    logic [rrp_pkg::COORD_W-1:0]       hr_lim, vr_lim, hr, vr;
    logic [rrp_pkg::PROD_W-1:0]        hprod, vprod;
    rrp_pkg::half_t                    xh, yh, hr_h, vr_h, hk_h, vk_h;
    logic                              is_empty;

    logic out_load, seq_adv, seq_end, geom_free, raw_adv, rect_fire;

    assign out_load  = !out_valid_reg || path.ready;
    assign seq_adv   = geom_valid_reg && out_load;
    assign seq_end   = (cmd_next == rrp_pkg::CMD_END);
    assign geom_free = !geom_valid_reg || (seq_adv && seq_end);
    assign raw_adv   = raw_valid_reg && geom_free;
    assign rect.ready = !raw_valid_reg || geom_free;
    assign rect_fire = rect.valid && rect.ready;

    // geometry in half-pixel units
    always_comb
    begin
        xh     = (rrp_pkg::half_t'(raw_x_reg) <<< 1) + rrp_pkg::half_t'(raw_adj_reg);
        yh     = (rrp_pkg::half_t'(raw_y_reg) <<< 1) + rrp_pkg::half_t'(raw_adj_reg);
        aw     = {raw_w_reg, 1'b0} - (raw_adj_reg ? rrp_pkg::EXT_W'(2) : '0);
        ah     = {raw_h_reg, 1'b0} - (raw_adj_reg ? rrp_pkg::EXT_W'(2) : '0);
        rad2   = {raw_rad_reg, 1'b0};
        hr_lim = aw[rrp_pkg::EXT_W-1:1];
        vr_lim = ah[rrp_pkg::EXT_W-1:1];
        hr     = (rad2 < {1'b0, hr_lim}) ? rad2[rrp_pkg::COORD_W-1:0] : hr_lim;
        vr     = (rad2 < {1'b0, vr_lim}) ? rad2[rrp_pkg::COORD_W-1:0] : vr_lim;
        hr_h   = rrp_pkg::half_t'({{(rrp_pkg::HALF_W-rrp_pkg::COORD_W){1'b0}}, hr});
        vr_h   = rrp_pkg::half_t'({{(rrp_pkg::HALF_W-rrp_pkg::COORD_W){1'b0}}, vr});
        hprod  = rrp_pkg::PROD_W'(hr) * rrp_pkg::PROD_W'(rrp_pkg::KAPPA_NUM);
        vprod  = rrp_pkg::PROD_W'(vr) * rrp_pkg::PROD_W'(rrp_pkg::KAPPA_NUM);
        hk_next = hprod[rrp_pkg::PROD_W-1:rrp_pkg::KAPPA_SHIFT];
        vk_next = vprod[rrp_pkg::PROD_W-1:rrp_pkg::KAPPA_SHIFT];

        x0_next = xh;
        y0_next = yh;
        x1_next = xh + rrp_pkg::half_t'({{(rrp_pkg::HALF_W-rrp_pkg::EXT_W){1'b0}}, aw});
        y1_next = yh + rrp_pkg::half_t'({{(rrp_pkg::HALF_W-rrp_pkg::EXT_W){1'b0}}, ah});
        l_next  = xh + hr_h;
        t_next  = yh + vr_h;
        r_next  = x1_next - hr_h;
        b_next  = y1_next - vr_h;

        is_empty = (raw_w_reg == '0) || (raw_h_reg == '0) ||
                   (raw_adj_reg && ((raw_w_reg <= rrp_pkg::COORD_W'(1)) ||
                                    (raw_h_reg <= rrp_pkg::COORD_W'(1))));
        // a corner offset is zero exactly when its radius is 0 or 1
        if (is_empty)
        begin
            kind_next = KIND_EMPTY;
        end
        else if ((hr <= rrp_pkg::COORD_W'(1)) && (vr <= rrp_pkg::COORD_W'(1)))
        begin
            kind_next = KIND_PLAIN;
        end
        else
        begin
            kind_next = KIND_ROUND;
        end
    end

    // command sequencer
    always_comb
    begin
        hk_h     = rrp_pkg::half_t'({{(rrp_pkg::HALF_W-rrp_pkg::COORD_W){1'b0}}, hk_reg});
        vk_h     = rrp_pkg::half_t'({{(rrp_pkg::HALF_W-rrp_pkg::COORD_W){1'b0}}, vk_reg});
        cmd_next = rrp_pkg::CMD_END;
        p1x_next = '0;
        p1y_next = '0;
        p2x_next = '0;
        p2y_next = '0;
        p3x_next = '0;
        p3y_next = '0;
        case (kind_reg)
            KIND_PLAIN:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        cmd_next = rrp_pkg::CMD_MOVE;
                        p1x_next = x0_reg; p1y_next = y0_reg;
                    end
                    4'd1:
                    begin
                        cmd_next = rrp_pkg::CMD_LINE;
                        p1x_next = x1_reg; p1y_next = y0_reg;
                    end
                    4'd2:
                    begin
                        cmd_next = rrp_pkg::CMD_LINE;
                        p1x_next = x1_reg; p1y_next = y1_reg;
                    end
                    4'd3:
                    begin
                        cmd_next = rrp_pkg::CMD_LINE;
                        p1x_next = x0_reg; p1y_next = y1_reg;
                    end
                    4'd4:    cmd_next = rrp_pkg::CMD_CLOSE;
                    default: cmd_next = rrp_pkg::CMD_END;
                endcase
            end
            KIND_ROUND:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        cmd_next = rrp_pkg::CMD_MOVE;
                        p1x_next = r_reg; p1y_next = y0_reg;
                    end
                    4'd1:
                    begin
                        cmd_next = rrp_pkg::CMD_CUBIC;
                        p1x_next = r_reg + hk_h; p1y_next = y0_reg;
                        p2x_next = x1_reg;       p2y_next = t_reg - vk_h;
                        p3x_next = x1_reg;       p3y_next = t_reg;
                    end
                    4'd2:
                    begin
                        cmd_next = rrp_pkg::CMD_LINE;
                        p1x_next = x1_reg; p1y_next = b_reg;
                    end
                    4'd3:
                    begin
                        cmd_next = rrp_pkg::CMD_CUBIC;
                        p1x_next = x1_reg;       p1y_next = b_reg + vk_h;
                        p2x_next = r_reg + hk_h; p2y_next = y1_reg;
                        p3x_next = r_reg;        p3y_next = y1_reg;
                    end
                    4'd4:
                    begin
                        cmd_next = rrp_pkg::CMD_LINE;
                        p1x_next = l_reg; p1y_next = y1_reg;
                    end
                    4'd5:
                    begin
                        cmd_next = rrp_pkg::CMD_CUBIC;
                        p1x_next = l_reg - hk_h; p1y_next = y1_reg;
                        p2x_next = x0_reg;       p2y_next = b_reg + vk_h;
                        p3x_next = x0_reg;       p3y_next = b_reg;
                    end
                    4'd6:
                    begin
                        cmd_next = rrp_pkg::CMD_LINE;
                        p1x_next = x0_reg; p1y_next = t_reg;
                    end
                    4'd7:
                    begin
                        cmd_next = rrp_pkg::CMD_CUBIC;
                        p1x_next = x0_reg;       p1y_next = t_reg - vk_h;
                        p2x_next = l_reg - hk_h; p2y_next = y0_reg;
                        p3x_next = l_reg;        p3y_next = y0_reg;
                    end
                    4'd8:    cmd_next = rrp_pkg::CMD_CLOSE;
                    default: cmd_next = rrp_pkg::CMD_END;
                endcase
            end
            default: cmd_next = rrp_pkg::CMD_END;
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid_reg  <= 1'b0;
            geom_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            if (rect_fire)
            begin
                raw_valid_reg <= 1'b1;
            end
            else if (raw_adv)
            begin
                raw_valid_reg <= 1'b0;
            end
            if (geom_free)
            begin
                geom_valid_reg <= raw_valid_reg;
                step_reg       <= '0;
            end
            else if (seq_adv)
            begin
                step_reg <= step_reg + rrp_pkg::STEP_W'(1);
            end
            out_valid_reg <= seq_adv || (out_valid_reg && !path.ready);
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rect_fire)
        begin
            raw_x_reg   <= rect.rect_x;
            raw_y_reg   <= rect.rect_y;
            raw_w_reg   <= rect.rect_width;
            raw_h_reg   <= rect.rect_height;
            raw_rad_reg <= rect.corner_radius;
            raw_adj_reg <= rect.pixel_adjust;
        end
        if (raw_adv)
        begin
            kind_reg <= kind_next;
            x0_reg   <= x0_next;
            y0_reg   <= y0_next;
            x1_reg   <= x1_next;
            y1_reg   <= y1_next;
            l_reg    <= l_next;
            r_reg    <= r_next;
            t_reg    <= t_next;
            b_reg    <= b_next;
            hk_reg   <= hk_next;
            vk_reg   <= vk_next;
        end
        if (seq_adv)
        begin
            cmd_reg <= cmd_next;
            p1x_reg <= rrp_pkg::fix_pt(p1x_next);
            p1y_reg <= rrp_pkg::fix_pt(p1y_next);
            p2x_reg <= rrp_pkg::fix_pt(p2x_next);
            p2y_reg <= rrp_pkg::fix_pt(p2y_next);
            p3x_reg <= rrp_pkg::fix_pt(p3x_next);
            p3y_reg <= rrp_pkg::fix_pt(p3y_next);
        end
    end

    assign path.valid    = out_valid_reg;
    assign path.cmd_code = cmd_reg;
    assign path.pt1_x    = p1x_reg;
    assign path.pt1_y    = p1y_reg;
    assign path.pt2_x    = p2x_reg;
    assign path.pt2_y    = p2y_reg;
    assign path.pt3_x    = p3x_reg;
    assign path.pt3_y    = p3y_reg;
    assign path.is_last  = (cmd_reg == rrp_pkg::CMD_END);

    a_empty_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        (geom_valid_reg && kind_reg == KIND_EMPTY) |-> (step_reg == '0))
        else $error("empty rectangle sequencer past its only command");

    a_plain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (geom_valid_reg && kind_reg == KIND_PLAIN) |-> (step_reg <= LAST_PLAIN))
        else $error("plain rectangle sequencer past its end command");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_adv && seq_end) |=> (step_reg == '0))
        else $error("sequencer did not restart after end command");

    a_bare_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (cmd_reg == rrp_pkg::CMD_CLOSE || cmd_reg == rrp_pkg::CMD_END))
        |-> (p1x_reg == '0 && p1y_reg == '0 && p2x_reg == '0 && p2y_reg == '0 &&
             p3x_reg == '0 && p3y_reg == '0))
        else $error("close or end command carries points");

endmodule
